>>> rtl/lthr_pkg.sv
// ----------------------------------------------------------------------------
// lthr_pkg
// Shared types, constants and the luma function of the row detector.
// ----------------------------------------------------------------------------
package lthr_pkg;

  localparam int COUNT_BITS_DEF = 12;
  localparam int CFG_W          = 12;
  localparam int THR_W          = 8;
  localparam int PIX_W          = 8;
  localparam int LUMA_W         = 15;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 4;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 12'd488;
  localparam logic [THR_W-1:0] DARK_THR_RST    = 8'd80;
  localparam logic [CFG_W-1:0] START_CNT_RST   = 12'd35;
  localparam logic [CFG_W-1:0] END_CNT_RST     = 12'd488;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_DARK_THRESHOLD = 2'd1,
    REG_START_COUNT    = 2'd2,
    REG_END_COUNT      = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CLASS_LIGHT     = 2'd0,
    CLASS_DARK      = 2'd1,
    CLASS_AFTER_END = 2'd2
  } pixel_class_t;

  typedef struct packed {
    logic [CFG_W-1:0]  image_width;
    logic [LUMA_W-1:0] dark_limit;   // 100 * (dark_threshold + 1)
    logic [CFG_W-1:0]  start_count;
    logic [CFG_W-1:0]  end_count;
  } cfg_t;

  typedef struct packed {
    pixel_class_t      pixel_class;
    logic              start_found;
    logic              end_found;
    logic [CFG_W-1:0]  end_row;
  } result_t;

  // 30r + 59g + 11b as shift-adds
  function automatic logic [LUMA_W-1:0] luma100(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [LUMA_W-1:0] rr, gg, bb;
    rr = LUMA_W'(r);
    gg = LUMA_W'(g);
    bb = LUMA_W'(b);
    return ((rr << 5) - (rr << 1))
         + ((gg << 6) - (gg << 2) - gg)
         + ((bb << 3) + (bb << 1) + bb);
  endfunction

  function automatic logic [LUMA_W-1:0] dark_limit(input logic [THR_W-1:0] thr);
    logic [LUMA_W-1:0] t;
    t = LUMA_W'(thr) + LUMA_W'(1);
    return (t << 6) + (t << 5) + (t << 2);
  endfunction

endpackage

>>> rtl/luma_threshold_row_detector.sv
// ----------------------------------------------------------------------------
// luma_threshold_row_detector
// Classes raster-order RGB pixels by luma and finds the start and end rows.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per pixel. Each pixel
// passes through the luma register and then the result register, which
// loads as the row counters and flags are updated. Throughput
// is one pixel per cycle while the output side keeps taking results; a stall
// at the output holds both stages and drops in_ready only when both are full.
// No clearing pass after reset. Configure only while the block is idle.
module luma_threshold_row_detector #(
  parameter int COUNT_BITS = lthr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lthr_pkg::PIX_W-1:0]        in_red,
  input  logic [lthr_pkg::PIX_W-1:0]        in_green,
  input  logic [lthr_pkg::PIX_W-1:0]        in_blue,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_pixel_class,
  output logic                              out_start_found,
  output logic                              out_end_found,
  output logic [lthr_pkg::CFG_W-1:0]        out_end_row,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lthr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lthr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lthr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lthr_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic              s1_valid_r;
  logic [LUMA_W-1:0] s1_luma_r;
  logic              s1_fs_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              out_free;
  logic              s2_take;
  logic              in_take;

  lthr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lthr_tracker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s2_take),
    .luma        (s1_luma_r),
    .frame_start (s1_fs_r),
    .cfg         (cfg),
    .result      (result)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s2_take  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_luma_r <= luma100(in_red, in_green, in_blue);
      s1_fs_r   <= in_frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // hold the result while the transaction is stalled
  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_class = out_r.pixel_class;
  assign out_start_found = out_r.start_found;
  assign out_end_found   = out_r.end_found;
  assign out_end_row     = out_r.end_row;

endmodule

>>> rtl/lthr_cfg.sv
// ----------------------------------------------------------------------------
// lthr_cfg
// APB register file; keeps the dark limit precomputed from the threshold.
// ----------------------------------------------------------------------------
module lthr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lthr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lthr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lthr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output lthr_pkg::cfg_t                    cfg
);
  import lthr_pkg::*;

  logic [CFG_W-1:0]  width_r;
  logic [THR_W-1:0]  thr_r;
  logic [LUMA_W-1:0] limit_r;
  logic [CFG_W-1:0]  start_r;
  logic [CFG_W-1:0]  end_r;
  logic [1:0]        idx;
  logic              wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= IMAGE_WIDTH_RST;
      thr_r   <= DARK_THR_RST;
      limit_r <= dark_limit(DARK_THR_RST);
      start_r <= START_CNT_RST;
      end_r   <= END_CNT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH: width_r <= pwdata[CFG_W-1:0];
        REG_DARK_THRESHOLD: begin
          thr_r   <= pwdata[THR_W-1:0];
          limit_r <= dark_limit(pwdata[THR_W-1:0]);
        end
        REG_START_COUNT: start_r <= pwdata[CFG_W-1:0];
        REG_END_COUNT:   end_r   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(width_r);
      REG_DARK_THRESHOLD: prdata = APB_DATA_W'(thr_r);
      REG_START_COUNT:    prdata = APB_DATA_W'(start_r);
      REG_END_COUNT:      prdata = APB_DATA_W'(end_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.image_width = width_r;
  assign cfg.dark_limit  = limit_r;
  assign cfg.start_count = start_r;
  assign cfg.end_count   = end_r;

endmodule

>>> rtl/lthr_tracker.sv
// ----------------------------------------------------------------------------
// lthr_tracker
// Column/row counters, light and dark run counters and the sticky flags.
// ----------------------------------------------------------------------------
module lthr_tracker #(
  parameter int COUNT_BITS = lthr_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [lthr_pkg::LUMA_W-1:0]   luma,
  input  logic                          frame_start,
  input  lthr_pkg::cfg_t                cfg,
  output lthr_pkg::result_t             result
);
  import lthr_pkg::*;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  cnt_t col_r, row_r, light_r, dark_r, found_r;
  logic start_r, end_r;

  cnt_t col0, row0, light0, dark0, found0;
  logic start0, end0;
  cnt_t col_inc, light_inc_v, dark_inc_v;
  cnt_t light1, dark1, found1;
  cnt_t col_nxt, row_nxt, light_nxt, dark_nxt;
  logic start1, end1;
  logic light_hit, dark_hit, row_end;
  pixel_class_t cls;

  always_comb begin
    // a frame start clears everything before the pixel is handled
    col0   = frame_start ? '0 : col_r;
    row0   = frame_start ? '0 : row_r;
    light0 = frame_start ? '0 : light_r;
    dark0  = frame_start ? '0 : dark_r;
    found0 = frame_start ? '0 : found_r;
    start0 = frame_start ? 1'b0 : start_r;
    end0   = frame_start ? 1'b0 : end_r;

    if (end0) begin
      cls = CLASS_AFTER_END;
    end else if (luma < cfg.dark_limit) begin
      cls = CLASS_DARK;
    end else begin
      cls = CLASS_LIGHT;
    end

    light_inc_v = light0 + cnt_t'(1);
    light_hit   = (cls == CLASS_LIGHT) && !start0;
    light1      = light_hit ? light_inc_v : light0;
    start1      = start0 | (light_hit && (light_inc_v == cnt_t'(cfg.start_count)));

    dark_inc_v = dark0 + cnt_t'(1);
    dark_hit   = (cls == CLASS_DARK) && start1;
    dark1      = dark_hit ? dark_inc_v : dark0;
    end1       = end0 | (dark_hit && (dark_inc_v == cnt_t'(cfg.end_count)));
    found1     = (!end0 && end1) ? row0 : found0;

    col_inc   = col0 + cnt_t'(1);
    row_end   = (col_inc == cnt_t'(cfg.image_width));
    col_nxt   = row_end ? '0 : col_inc;
    row_nxt   = row_end ? row0 + cnt_t'(1) : row0;
    light_nxt = (row_end && !start1) ? '0 : light1;
    dark_nxt  = (row_end && !end1) ? '0 : dark1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      light_r <= '0;
      dark_r  <= '0;
      found_r <= '0;
      start_r <= 1'b0;
      end_r   <= 1'b0;
    end else if (fire) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      light_r <= light_nxt;
      dark_r  <= dark_nxt;
      found_r <= found1;
      start_r <= start1;
      end_r   <= end1;
    end
  end

  assign result.pixel_class = cls;
  assign result.start_found = start1;
  assign result.end_found   = end1;
  assign result.end_row     = CFG_W'(found1);

endmodule

>>> rtl/lthr_checker.sv
// ----------------------------------------------------------------------------
// lthr_checker
// Port-level checks on the result stream of the row detector.
// ----------------------------------------------------------------------------
module lthr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_pixel_class,
  input logic                       out_start_found,
  input logic                       out_end_found,
  input logic [lthr_pkg::CFG_W-1:0] out_end_row
);
  import lthr_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_class)
      && $stable(out_start_found) && $stable(out_end_found) && $stable(out_end_row))
    else $error("result changed while stalled");

  a_end_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_found |-> out_start_found)
    else $error("end flag without start flag");

  a_after_end_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_class == CLASS_AFTER_END |-> out_end_found)
    else $error("post-end class without end flag");

  a_row_zero_before_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_found |-> out_end_row == '0)
    else $error("end row set before end found");

endmodule

bind luma_threshold_row_detector lthr_checker u_lthr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_class (out_pixel_class),
  .out_start_found (out_start_found),
  .out_end_found   (out_end_found),
  .out_end_row     (out_end_row)
);
